// ----- hw/rtl/rizb_pkg.sv -----
// rizb_pkg: shared types and constants of the range image z-buffer core
// no dependencies; used by rizb_mac and range_image_zbuffer_projection_core
`default_nettype none

package rizb_pkg;

	// default image store size
	localparam int DEF_MAX_COLS = 1024;
	localparam int DEF_MAX_ROWS = 64;

	// quotient bits of the projection divider (covers the largest store side)
	localparam int DIV_QW = 13;

	// accumulator width of the shared multiply-accumulate unit
	localparam int MAC_OW = 51;

	// item function codes
	localparam logic [1:0] FUNC_INSERT = 2'd0;
	localparam logic [1:0] FUNC_READ   = 2'd1;
	localparam logic [1:0] FUNC_CLEAR  = 2'd2;

	// result outcome codes
	localparam logic [1:0] OUT_STORED = 2'd0;
	localparam logic [1:0] OUT_HIDDEN = 2'd1;
	localparam logic [1:0] OUT_OFF    = 2'd2;
	localparam logic [1:0] OUT_DONE   = 2'd3;

	// configuration register indexes
	localparam logic [2:0] CFG_FOCAL_X  = 3'd0;
	localparam logic [2:0] CFG_FOCAL_Y  = 3'd1;
	localparam logic [2:0] CFG_CENTER_X = 3'd2;
	localparam logic [2:0] CFG_CENTER_Y = 3'd3;
	localparam logic [2:0] CFG_COLS     = 3'd4;
	localparam logic [2:0] CFG_ROWS     = 3'd5;

	// control of one multiply-accumulate step
	typedef struct packed {
		logic valid;
		logic first;
		logic neg;
	} mac_ctl_t;

endpackage

`default_nettype wire

// ----- hw/rtl/range_image_zbuffer_projection_core.sv -----
// range_image_zbuffer_projection_core: pinhole projection into a nearest-range image store
// depends on rizb_pkg and rizb_mac
// insert: multiply, divide and check per coordinate, then square root, address, read, compare;
//   dropped early when off the image, straight to the result for a zero forward coordinate;
//   read: address, read, compare; clear: sweeps the whole store; func 3: straight to the result
// throughput: one item at a time; the shared multiplier, the shared subtractor
//   (13+1 divide steps per coordinate, 24 square root steps) and the store port set it
// reset: registers take their reset values, then a sweep over all MAX_ROWS*MAX_COLS entries
//   zeroes the store while no item is taken; configuration writes are taken meanwhile
`default_nettype none

module range_image_zbuffer_projection_core #(
	parameter int MAX_COLS = rizb_pkg::DEF_MAX_COLS,
	parameter int MAX_ROWS = rizb_pkg::DEF_MAX_ROWS
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic [2:0]         cfg_index,
	input  wire logic [23:0]        cfg_data,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [1:0]         func,
	input  wire logic signed [23:0] point_x,
	input  wire logic signed [23:0] point_y,
	input  wire logic signed [23:0] point_z,
	input  wire logic [5:0]         pixel_row,
	input  wire logic [9:0]         pixel_col,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [23:0]             range_value,
	output logic [1:0]              outcome
);
	import rizb_pkg::*;

	localparam int DEPTH = MAX_ROWS * MAX_COLS;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_MUL, S_DIV, S_CHK, S_SQRT, S_ADDR, S_RD, S_CMP, S_DONE
	} state_t;

	typedef enum logic [1:0] {PH_COL, PH_ROW, PH_RNG} phase_t;

	// configuration registers
	logic [23:0]        focal_x_q, focal_y_q;
	logic signed [23:0] center_x_q, center_y_q;
	logic [10:0]        cols_q;
	logic [6:0]         rows_q;

	// sequencer and datapath registers
	state_t              state_q;
	phase_t              phase_q;
	logic [4:0]          cnt_q;
	logic [1:0]          func_q;
	logic signed [23:0]  x_q, y_q, z_q;
	logic [50:0]         rem_q, res_q;
	logic [31:0]         dvs_q;
	logic                neg_q, over_q;
	logic [DIV_QW-1:0]   q_q, col_q, row_q;
	logic [23:0]         rng_q;
	logic [AW-1:0]       addr_q, clr_addr_q;
	logic                oob_q, clr_item_q;
	logic [23:0]         res_range_q;
	logic [1:0]          res_outc_q;

	// store
	logic [23:0]   mem [DEPTH];
	logic [23:0]   rdata_q;
	logic          mem_we;
	logic [AW-1:0] mem_wa;
	logic [23:0]   mem_wd;

	// shared unit signals
	logic signed [24:0]         op_a, op_b;
	mac_ctl_t                   mctl;
	logic signed [MAC_OW-1:0]   acc;
	logic [50:0]                acc_abs;
	logic [23:0]                x_abs;
	logic [50:0]                sub_b, diff, sqrt_bit;
	logic                       borrow, ge;
	logic [4:0]                 mul_last;
	logic                       lim_ok, proj_ok, store_ok;
	logic [24:0]                rnd;
	logic [23:0]                rng_sat;
	logic [AW-1:0]              addr_next;

	rizb_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.op_a   (op_a),
		.op_b   (op_b),
		.ctl    (mctl),
		.acc    (acc)
	);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			focal_x_q  <= 24'd65536;
			focal_y_q  <= 24'd65536;
			center_x_q <= 24'sd131072;
			center_y_q <= 24'sd8192;
			cols_q     <= 11'd1024;
			rows_q     <= 7'd64;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_FOCAL_X:  focal_x_q  <= cfg_data;
				CFG_FOCAL_Y:  focal_y_q  <= cfg_data;
				CFG_CENTER_X: center_x_q <= cfg_data;
				CFG_CENTER_Y: center_y_q <= cfg_data;
				CFG_COLS:     cols_q     <= cfg_data[10:0];
				CFG_ROWS:     rows_q     <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	// multiplier operand selection per phase and step
	always_comb begin
		op_a     = '0;
		op_b     = '0;
		mctl     = '0;
		mul_last = (phase_q == PH_RNG) ? 5'd3 : 5'd2;
		if (state_q == S_MUL) begin
			unique case (phase_q)
				PH_COL: begin
					if (cnt_q == 5'd0) begin
						op_a = {center_x_q[23], center_x_q};
						op_b = {x_q[23], x_q};
						mctl = '{valid: 1'b1, first: 1'b1, neg: 1'b0};
					end else if (cnt_q == 5'd1) begin
						op_a = {1'b0, focal_x_q};
						op_b = {y_q[23], y_q};
						mctl = '{valid: 1'b1, first: 1'b0, neg: 1'b1};
					end
				end
				PH_ROW: begin
					if (cnt_q == 5'd0) begin
						op_a = {center_y_q[23], center_y_q};
						op_b = {x_q[23], x_q};
						mctl = '{valid: 1'b1, first: 1'b1, neg: 1'b0};
					end else if (cnt_q == 5'd1) begin
						op_a = {1'b0, focal_y_q};
						op_b = {z_q[23], z_q};
						mctl = '{valid: 1'b1, first: 1'b0, neg: 1'b0};
					end
				end
				default: begin
					if (cnt_q == 5'd0) begin
						op_a = {x_q[23], x_q};
						op_b = {x_q[23], x_q};
						mctl = '{valid: 1'b1, first: 1'b1, neg: 1'b0};
					end else if (cnt_q == 5'd1) begin
						op_a = {y_q[23], y_q};
						op_b = {y_q[23], y_q};
						mctl = '{valid: 1'b1, first: 1'b0, neg: 1'b0};
					end else if (cnt_q == 5'd2) begin
						op_a = {z_q[23], z_q};
						op_b = {z_q[23], z_q};
						mctl = '{valid: 1'b1, first: 1'b0, neg: 1'b0};
					end
				end
			endcase
		end
	end

	// shared subtract and compare: divide steps and square root steps
	always_comb begin
		acc_abs  = acc[MAC_OW-1] ? 51'(-acc) : 51'(acc);
		x_abs    = x_q[23] ? 24'(-x_q) : 24'(x_q);
		sqrt_bit = 51'd1 << {cnt_q, 1'b0};
		if (state_q == S_DIV)
			sub_b = {19'd0, dvs_q} << cnt_q[3:0];
		else if (state_q == S_SQRT)
			sub_b = res_q + sqrt_bit;
		else
			sub_b = '0;
		{borrow, diff} = {1'b0, rem_q} - {1'b0, sub_b};
		ge = !borrow;
	end

	// projection bound check, rounding and store address
	always_comb begin
		if (phase_q == PH_COL)
			lim_ok = (q_q < {2'd0, cols_q}) && (int'(q_q) < MAX_COLS);
		else
			lim_ok = (q_q < {6'd0, rows_q}) && (int'(q_q) < MAX_ROWS);
		proj_ok   = !over_q && !(neg_q && (q_q != '0)) && lim_ok;
		rnd       = (rem_q > {26'd0, res_q[24:0]}) ? (res_q[24:0] + 25'd1) : res_q[24:0];
		rng_sat   = rnd[24] ? '1 : rnd[23:0];
		addr_next = AW'(int'(row_q) * MAX_COLS + int'(col_q));
		store_ok  = (rdata_q == '0) || (rng_q < rdata_q);
	end

	// store write port
	always_comb begin
		mem_we = (state_q == S_CLEAR) ||
			((state_q == S_CMP) && (func_q == FUNC_INSERT) && store_ok);
		mem_wa = (state_q == S_CLEAR) ? clr_addr_q : addr_q;
		mem_wd = (state_q == S_CLEAR) ? '0 : rng_q;
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_wa] <= mem_wd;
		rdata_q <= mem[addr_q];
	end

	assign in_stall = (state_q != S_IDLE);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			phase_q     <= PH_COL;
			cnt_q       <= '0;
			func_q      <= '0;
			x_q         <= '0;
			y_q         <= '0;
			z_q         <= '0;
			rem_q       <= '0;
			res_q       <= '0;
			dvs_q       <= '0;
			neg_q       <= 1'b0;
			over_q      <= 1'b0;
			q_q         <= '0;
			col_q       <= '0;
			row_q       <= '0;
			rng_q       <= '0;
			addr_q      <= '0;
			oob_q       <= 1'b0;
			clr_addr_q  <= '0;
			clr_item_q  <= 1'b0;
			res_range_q <= '0;
			res_outc_q  <= '0;
			out_valid   <= 1'b0;
			range_value <= '0;
			outcome     <= '0;
		end else begin
			// the done state handles the result register itself
			if (out_valid && !out_stall && (state_q != S_DONE))
				out_valid <= 1'b0;
			unique case (state_q)
				S_CLEAR: begin
					clr_addr_q <= clr_addr_q + 1'b1;
					if (clr_addr_q == AW'(DEPTH - 1)) begin
						clr_addr_q <= '0;
						if (clr_item_q) begin
							clr_item_q  <= 1'b0;
							res_range_q <= '0;
							res_outc_q  <= OUT_DONE;
							state_q     <= S_DONE;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						func_q <= func;
						x_q    <= point_x;
						y_q    <= point_y;
						z_q    <= point_z;
						case (func)
							FUNC_INSERT: begin
								if (point_x == '0) begin
									res_range_q <= '0;
									res_outc_q  <= OUT_OFF;
									state_q     <= S_DONE;
								end else begin
									phase_q <= PH_COL;
									cnt_q   <= '0;
									state_q <= S_MUL;
								end
							end
							FUNC_READ: begin
								col_q   <= DIV_QW'(pixel_col);
								row_q   <= DIV_QW'(pixel_row);
								state_q <= S_ADDR;
							end
							FUNC_CLEAR: begin
								clr_item_q <= 1'b1;
								state_q    <= S_CLEAR;
							end
							default: begin
								res_range_q <= '0;
								res_outc_q  <= OUT_DONE;
								state_q     <= S_DONE;
							end
						endcase
					end
				end
				S_MUL: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == mul_last) begin
						if (phase_q == PH_RNG) begin
							cnt_q   <= 5'd24;
							state_q <= S_SQRT;
						end else begin
							cnt_q   <= 5'd14;
							state_q <= S_DIV;
						end
					end
				end
				S_DIV: begin
					if (cnt_q == 5'd14) begin
						// load magnitudes, sign of the quotient
						rem_q  <= acc_abs;
						neg_q  <= acc[MAC_OW-1] ^ x_q[23];
						dvs_q  <= {x_abs, 8'd0};
						over_q <= 1'b0;
						q_q    <= '0;
						cnt_q  <= 5'd13;
					end else if (cnt_q == 5'd13) begin
						// quotient too large for any image side
						if (ge) begin
							over_q  <= 1'b1;
							state_q <= S_CHK;
						end else begin
							cnt_q <= 5'd12;
						end
					end else begin
						if (ge) begin
							rem_q           <= diff;
							q_q[cnt_q[3:0]] <= 1'b1;
						end
						if (cnt_q == 5'd0)
							state_q <= S_CHK;
						else
							cnt_q <= cnt_q - 5'd1;
					end
				end
				S_CHK: begin
					cnt_q <= '0;
					if (!proj_ok) begin
						res_range_q <= '0;
						res_outc_q  <= OUT_OFF;
						state_q     <= S_DONE;
					end else if (phase_q == PH_COL) begin
						col_q   <= q_q;
						phase_q <= PH_ROW;
						state_q <= S_MUL;
					end else begin
						row_q   <= q_q;
						phase_q <= PH_RNG;
						state_q <= S_MUL;
					end
				end
				S_SQRT: begin
					if (cnt_q == 5'd24) begin
						rem_q <= acc_abs;
						res_q <= '0;
						cnt_q <= 5'd23;
					end else begin
						// one result bit per step
						if (ge) begin
							rem_q <= diff;
							res_q <= (res_q >> 1) + sqrt_bit;
						end else begin
							res_q <= res_q >> 1;
						end
						if (cnt_q == 5'd0)
							state_q <= S_ADDR;
						else
							cnt_q <= cnt_q - 5'd1;
					end
				end
				S_ADDR: begin
					addr_q  <= addr_next;
					rng_q   <= rng_sat;
					oob_q   <= (int'(row_q) >= MAX_ROWS) || (int'(col_q) >= MAX_COLS);
					state_q <= S_RD;
				end
				S_RD: begin
					state_q <= S_CMP;
				end
				S_CMP: begin
					if (func_q == FUNC_READ) begin
						res_range_q <= oob_q ? '0 : rdata_q;
						res_outc_q  <= OUT_DONE;
					end else begin
						res_range_q <= rng_q;
						res_outc_q  <= store_ok ? OUT_STORED : OUT_HIDDEN;
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (!out_valid || !out_stall) begin
						out_valid   <= 1'b1;
						range_value <= res_range_q;
						outcome     <= res_outc_q;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef ASSERT_OFF
	// a result beat only appears out of the final state
	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q) == S_DONE)
		else $error("result raised outside done state");

	// square root remainder bound after the last step
	a_sqrt_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ADDR) && (func_q == FUNC_INSERT) |-> rem_q <= (res_q << 1))
		else $error("square root remainder out of bound");

	// an insert never writes an empty marker
	a_store_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we && (state_q != S_CLEAR) |-> mem_wd != '0)
		else $error("insert wrote zero range");

	// column accepted before the row is checked
	a_col_in_store: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CHK) && (phase_q == PH_ROW) |-> int'(col_q) < MAX_COLS)
		else $error("column outside store");
`endif

endmodule

`default_nettype wire

// ----- hw/rtl/rizb_mac.sv -----
// rizb_mac: shared 25x25 signed multiplier with registered product and accumulator
// depends on rizb_pkg
`default_nettype none

module rizb_mac (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic signed [24:0]                   op_a,
	input  wire logic signed [24:0]                   op_b,
	input  wire rizb_pkg::mac_ctl_t                   ctl,
	output logic signed [rizb_pkg::MAC_OW-1:0]        acc
);
	import rizb_pkg::*;

	logic signed [49:0]        prod_s1;
	mac_ctl_t                  ctl_s1;
	logic signed [MAC_OW-1:0]  acc_q;
	logic signed [MAC_OW-1:0]  prod_ext;
	logic signed [MAC_OW-1:0]  base;

	// product stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1  <= '0;
			prod_s1 <= '0;
		end else begin
			ctl_s1  <= ctl;
			prod_s1 <= op_a * op_b;
		end
	end

	// accumulate stage
	always_comb begin
		prod_ext = {{(MAC_OW-50){prod_s1[49]}}, prod_s1};
		base     = ctl_s1.first ? '0 : acc_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (ctl_s1.valid) begin
			acc_q <= ctl_s1.neg ? (base - prod_ext) : (base + prod_ext);
		end
	end

	assign acc = acc_q;

endmodule

`default_nettype wire
